### hdl/stpq_pkg.sv
package stpq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int ID_BITS     = 8;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [0:0] {
    MODE_INSERT = 1'b0,
    MODE_REMOVE = 1'b1
  } mode_t;

  typedef enum logic [1:0] {
    STATUS_DONE    = 2'd0,
    STATUS_FULL    = 2'd1,
    STATUS_MISSING = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } ctl_state_t;

  typedef struct packed {
    mode_t              mode;
    logic [7:0]         task_id;
    logic signed [31:0] priority_req;
  } in_item_t;

  typedef struct packed {
    status_t            status;
    logic               head_valid;
    logic [7:0]         head_id;
    logic signed [31:0] head_priority;
    logic [4:0]         entry_total;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } ctl_cmd_t;

  typedef struct packed {
    logic busy;
    logic out_free;
  } dp_status_t;

endpackage

### hdl/stpq_ctrl.sv
module stpq_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  stpq_pkg::dp_status_t status,
  output stpq_pkg::ctl_cmd_t   cmd
);
  import stpq_pkg::*;

  ctl_state_t state;
  ctl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.step = 1'b1;
        if (!status.busy) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == ST_SCAN)
    else $error("load did not start a scan");
  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> status.out_free)
    else $error("commit while result register busy");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> in_stall)
    else $error("input open while an item is in progress");

endmodule

### hdl/stpq_datapath.sv
module stpq_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  stpq_pkg::in_item_t   in_data,
  input  stpq_pkg::ctl_cmd_t   cmd,
  output stpq_pkg::dp_status_t status,
  output logic                 out_valid,
  input  logic                 out_stall,
  output stpq_pkg::out_item_t  out_data
);
  import stpq_pkg::*;

  logic [ID_BITS-1:0] mem_id   [QUEUE_DEPTH];
  logic signed [31:0] mem_prio [QUEUE_DEPTH];

  mode_t              req_mode;
  logic [ID_BITS-1:0] req_id;
  logic signed [31:0] req_prio;

  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_next;
  logic [CNT_W-1:0]   rd_idx;
  logic [CNT_W-1:0]   proc_idx;
  logic               proc_vld;
  logic [ID_BITS-1:0] rd_id;
  logic signed [31:0] rd_prio;
  logic [ID_BITS-1:0] carry_id;
  logic signed [31:0] carry_prio;
  logic               found;
  logic [ID_BITS-1:0] head_id;
  logic signed [31:0] head_prio;

  logic               full;
  logic [CNT_W-1:0]   lim;
  logic               rd_more;
  logic               place;
  logic               found_set;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [ID_BITS-1:0] wr_id;
  logic signed [31:0] wr_prio;
  status_t            res_status;

  assign full    = (count == CNT_W'(QUEUE_DEPTH));
  assign rd_more = (rd_idx < lim);
  assign place   = !found && ((proc_idx == count) || (rd_prio < req_prio));

  always_comb begin
    if (req_mode == MODE_INSERT) begin
      lim = full ? '0 : count + CNT_W'(1);
    end else begin
      lim = count;
    end
  end

  always_comb begin
    wr_en     = 1'b0;
    wr_addr   = proc_idx[IDX_W-1:0];
    wr_id     = req_id;
    wr_prio   = req_prio;
    found_set = 1'b0;
    if (proc_vld) begin
      if (req_mode == MODE_INSERT) begin
        if (found) begin
          wr_en   = 1'b1;
          wr_id   = carry_id;
          wr_prio = carry_prio;
        end else if (place) begin
          wr_en     = 1'b1;
          found_set = 1'b1;
        end
      end else begin
        if (found) begin
          wr_en   = 1'b1;
          wr_addr = IDX_W'(proc_idx - CNT_W'(1));
          wr_id   = rd_id;
          wr_prio = rd_prio;
        end else if (rd_id == req_id) begin
          found_set = 1'b1;
        end
      end
    end
  end

  always_comb begin
    count_next = count;
    res_status = STATUS_DONE;
    if (req_mode == MODE_INSERT) begin
      if (full) begin
        res_status = STATUS_FULL;
      end else begin
        count_next = count + CNT_W'(1);
      end
    end else begin
      if (found) begin
        count_next = count - CNT_W'(1);
      end else begin
        res_status = STATUS_MISSING;
      end
    end
  end

  assign status.busy     = rd_more || proc_vld;
  assign status.out_free = !out_valid || !out_stall;

  // table storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_id[wr_addr]   <= wr_id;
      mem_prio[wr_addr] <= wr_prio;
    end
    if (cmd.step) begin
      rd_id   <= mem_id[rd_idx[IDX_W-1:0]];
      rd_prio <= mem_prio[rd_idx[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_mode <= in_data.mode;
      req_id   <= in_data.task_id[ID_BITS-1:0];
      req_prio <= in_data.priority_req;
    end
    if (cmd.step) begin
      proc_idx <= rd_idx;
    end
    if (proc_vld && req_mode == MODE_INSERT && (found || place)) begin
      carry_id   <= rd_id;
      carry_prio <= rd_prio;
    end
    if (wr_en && wr_addr == '0) begin
      head_id   <= wr_id;
      head_prio <= wr_prio;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rd_idx    <= '0;
      proc_vld  <= 1'b0;
      found     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load) begin
        rd_idx   <= '0;
        proc_vld <= 1'b0;
        found    <= 1'b0;
      end else if (cmd.step) begin
        proc_vld <= rd_more;
        if (rd_more) begin
          rd_idx <= rd_idx + CNT_W'(1);
        end
        if (found_set) begin
          found <= 1'b1;
        end
      end
      if (cmd.commit) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data.status      <= res_status;
      out_data.entry_total <= 5'(count_next);
      if (count_next != '0) begin
        out_data.head_valid    <= 1'b1;
        out_data.head_id       <= 8'(head_id);
        out_data.head_priority <= head_prio;
      end else begin
        out_data.head_valid    <= 1'b0;
        out_data.head_id       <= '0;
        out_data.head_priority <= '0;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("entry count above depth");
  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    cmd.commit && req_mode == MODE_INSERT && !full |=> count == $past(count) + CNT_W'(1))
    else $error("insert did not add an entry");
  a_proc_range: assert property (@(posedge clk) disable iff (rst)
    proc_vld |-> proc_idx < lim)
    else $error("scan past end of table");
  a_head_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.head_valid == (out_data.entry_total != '0))
    else $error("head flag disagrees with entry total");

endmodule

### hdl/sorted_task_priority_queue.sv
// Each transaction is accepted, makes a single pass over the table through
// its one read and one write port (an insert into a full table and a remove
// from an empty table read no entries), and its result is then registered
// once the result register is free; a stalled result register holds it back.
// A new transaction is accepted only after the last one's result is registered.
// Reset (rst, synchronous): table empty, no result pending, input open.
module sorted_task_priority_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  stpq_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output stpq_pkg::out_item_t out_data
);
  import stpq_pkg::*;

  ctl_cmd_t   cmd;
  dp_status_t status;

  stpq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  stpq_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
